// ===== hdl/udc7_pkg.sv =====
// ----------------------------------------------------------------------------
// udc7_pkg
// shared types, constants and helper functions of the debounced up/down
// counter with seven-segment digit outputs
// ----------------------------------------------------------------------------
`default_nettype none

package udc7_pkg;

    localparam int KEY_W   = 8;
    localparam int COUNT_W = 14;
    localparam int SEG_W   = 8;
    localparam int REM_W   = 10;

    localparam logic [KEY_W-1:0]   KEY_IDLE          = 8'hFF;
    localparam logic [COUNT_W-1:0] MAX_COUNT         = 14'd9999;

    localparam logic [KEY_W-1:0]   RST_PRESS_TICKS   = 8'd10;
    localparam logic [COUNT_W-1:0] RST_COUNT_LIMIT   = 14'd9999;
    localparam logic [KEY_W-1:0]   RST_UP_CODE       = 8'hFB;
    localparam logic [KEY_W-1:0]   RST_DOWN_CODE     = 8'hF7;

    localparam logic [COUNT_W-1:0] UNIT_THOUSANDS    = 14'd1000;
    localparam logic [COUNT_W-1:0] UNIT_HUNDREDS     = 14'd100;
    localparam logic [COUNT_W-1:0] UNIT_TENS         = 14'd10;

    localparam logic [SEG_W-1:0]   SEG_BLANK         = 8'hFF;
    localparam logic [SEG_W-1:0]   SEG_ZERO          = 8'hC0;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_INC  = 2'd1,
        ACT_DEC  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        CFG_PRESS_TICKS = 2'd0,
        CFG_COUNT_LIMIT = 2'd1,
        CFG_UP_CODE     = 2'd2,
        CFG_DOWN_CODE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_W-1:0]   press_ticks;
        logic [COUNT_W-1:0] count_limit;
        logic [KEY_W-1:0]   up_code;
        logic [KEY_W-1:0]   down_code;
    } t_cfg;

    // beat leaving the key/count stage
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_action            action;
    } t_cnt_beat;

    // beat moving through the digit split stages
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_action            action;
        logic [REM_W-1:0]   rem;
        logic [SEG_W-1:0]   th_seg;
        logic [SEG_W-1:0]   hu_seg;
        logic [SEG_W-1:0]   te_seg;
        logic [SEG_W-1:0]   on_seg;
    } t_conv_beat;

    typedef struct packed {
        logic [3:0]         digit;
        logic [COUNT_W-1:0] rem;
    } t_split;

    // active-low segment pattern of one decimal digit
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // one decimal digit off the top: nine parallel compares against
    // multiples of the unit, value must stay below ten units
    function automatic t_split split_digit(input logic [COUNT_W-1:0] value,
                                           input logic [COUNT_W-1:0] unit);
        t_split             s;
        logic [COUNT_W-1:0] step;
        s.digit = '0;
        s.rem   = value;
        step    = '0;
        for (int k = 1; k <= 9; k++) begin
            step = step + unit;
            if (value >= step) begin
                s.digit = 4'(k);
                s.rem   = value - step;
            end
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/udc7_key_ctrl.sv =====
// ----------------------------------------------------------------------------
// udc7_key_ctrl
// input register, press debounce, release action and count update
// ----------------------------------------------------------------------------
`default_nettype none

module udc7_key_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire udc7_pkg::t_cfg                i_cfg,
    input  wire logic                          i_in_valid,
    output      logic                          o_in_ready,
    input  wire logic [udc7_pkg::KEY_W-1:0]    i_key_port,
    output      logic                          o_dn_valid,
    input  wire logic                          i_dn_ready,
    output      udc7_pkg::t_cnt_beat           o_dn_beat
);

    logic                            r_v0;
    logic [udc7_pkg::KEY_W-1:0]      r_key;
    logic                            r_v1;
    udc7_pkg::t_cnt_beat             r_beat;

    logic [udc7_pkg::KEY_W-1:0]      r_press_count, n_press_count;
    logic                            r_pending, n_pending;
    logic [udc7_pkg::KEY_W-1:0]      r_latched, n_latched;
    logic [udc7_pkg::COUNT_W-1:0]    r_count, n_count;
    udc7_pkg::t_action               n_action;

    logic [udc7_pkg::COUNT_W-1:0]    w_limit;
    logic [udc7_pkg::COUNT_W:0]      w_inc;
    logic                            w_rdy0, w_rdy1, w_adv;

    assign w_rdy1     = !r_v1 || i_dn_ready;
    assign w_rdy0     = !r_v0 || w_rdy1;
    assign w_adv      = r_v0 && w_rdy1;
    assign o_in_ready = w_rdy0;
    assign o_dn_valid = r_v1;
    assign o_dn_beat  = r_beat;

    // limits above the display range act as the display maximum
    assign w_limit = (i_cfg.count_limit > udc7_pkg::MAX_COUNT) ?
                     udc7_pkg::MAX_COUNT : i_cfg.count_limit;
    assign w_inc   = {1'b0, r_count} + 15'd1;

    always_comb begin
        n_press_count = r_press_count;
        n_pending     = r_pending;
        n_latched     = r_latched;
        n_count       = r_count;
        n_action      = udc7_pkg::ACT_NONE;
        if (r_key != udc7_pkg::KEY_IDLE) begin
            n_press_count = r_press_count + 8'd1;
            if (n_press_count == i_cfg.press_ticks) begin
                n_pending = 1'b1;
                n_latched = r_key;
            end
        end else begin
            n_press_count = '0;
            if (r_pending) begin
                n_pending = 1'b0;
                if (r_latched == i_cfg.up_code) begin
                    n_count  = (w_inc > {1'b0, w_limit}) ? w_limit
                                                         : w_inc[udc7_pkg::COUNT_W-1:0];
                    n_action = udc7_pkg::ACT_INC;
                end else if (r_latched == i_cfg.down_code) begin
                    if (r_count != '0) begin
                        n_count = r_count - 14'd1;
                    end
                    n_action = udc7_pkg::ACT_DEC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0          <= 1'b0;
            r_v1          <= 1'b0;
            r_press_count <= '0;
            r_pending     <= 1'b0;
            r_latched     <= '0;
            r_count       <= '0;
        end else begin
            if (w_rdy0) begin
                r_v0 <= i_in_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            if (w_adv) begin
                r_press_count <= n_press_count;
                r_pending     <= n_pending;
                r_latched     <= n_latched;
                r_count       <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0 && i_in_valid) begin
            r_key <= i_key_port;
        end
        if (w_adv) begin
            r_beat.count  <= n_count;
            r_beat.action <= n_action;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/udc7_digit_pipe.sv =====
// ----------------------------------------------------------------------------
// udc7_digit_pipe
// three-stage decimal split of the count into seven-segment patterns
// ----------------------------------------------------------------------------
`default_nettype none

module udc7_digit_pipe (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire udc7_pkg::t_cnt_beat   i_beat,
    output      logic                  o_valid,
    input  wire logic                  i_ready,
    output      udc7_pkg::t_conv_beat  o_beat
);

    logic [2:0]            r_v;
    udc7_pkg::t_conv_beat  r_b [3];
    udc7_pkg::t_conv_beat  n_b [3];
    logic [2:0]            w_rdy;
    udc7_pkg::t_split      w_sp0, w_sp1, w_sp2;

    assign w_rdy[2] = !r_v[2] || i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_v[2];
    assign o_beat   = r_b[2];

    assign w_sp0 = udc7_pkg::split_digit(i_beat.count, udc7_pkg::UNIT_THOUSANDS);
    assign w_sp1 = udc7_pkg::split_digit(14'(r_b[0].rem), udc7_pkg::UNIT_HUNDREDS);
    assign w_sp2 = udc7_pkg::split_digit(14'(r_b[1].rem), udc7_pkg::UNIT_TENS);

    always_comb begin
        // thousands
        n_b[0]        = '0;
        n_b[0].count  = i_beat.count;
        n_b[0].action = i_beat.action;
        n_b[0].rem    = w_sp0.rem[udc7_pkg::REM_W-1:0];
        n_b[0].th_seg = udc7_pkg::seg_of(w_sp0.digit);
        // hundreds
        n_b[1]        = r_b[0];
        n_b[1].rem    = w_sp1.rem[udc7_pkg::REM_W-1:0];
        n_b[1].hu_seg = udc7_pkg::seg_of(w_sp1.digit);
        // tens and ones
        n_b[2]        = r_b[1];
        n_b[2].rem    = w_sp2.rem[udc7_pkg::REM_W-1:0];
        n_b[2].te_seg = udc7_pkg::seg_of(w_sp2.digit);
        n_b[2].on_seg = udc7_pkg::seg_of(w_sp2.rem[3:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_rdy[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_b[0] <= n_b[0];
        end
        if (w_rdy[1] && r_v[0]) begin
            r_b[1] <= n_b[1];
        end
        if (w_rdy[2] && r_v[1]) begin
            r_b[2] <= n_b[2];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/debounced_updown_counter_7seg_core.sv =====
// ----------------------------------------------------------------------------
// debounced_updown_counter_7seg_core
// debounced two-key up/down counter with four seven-segment digit patterns
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per scan tick carrying the 8-bit key port sample
//   (i_in_valid / o_in_ready), a low bit means a key is down
//   output channel: one beat per input beat with the count, four active-low
//   segment patterns and the action code (o_out_valid / i_out_ready)
//   config port: i_cfg_we writes i_cfg_data into register i_cfg_index at the
//   clock edge, write only while no beat is in flight
// pipeline and throughput
//   an accepted input beat is loaded into the input register, then passes the
//   count update and one digit split stage per decimal place (thousands,
//   hundreds, tens/ones) before it shows on the output;
//   one beat per cycle sustained while the output does not stall
// reset
//   synchronous active-low; clears the pipeline, press counter, pending flag,
//   latched code and count, and loads the config register defaults
// stall
//   each stage holds its beat while the next is full; a stalled output
//   fills the five stages before o_in_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_updown_counter_7seg_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [1:0]                      i_cfg_index,
    input  wire logic [udc7_pkg::COUNT_W-1:0]    i_cfg_data,
    // input channel
    input  wire logic                            i_in_valid,
    output      logic                            o_in_ready,
    input  wire logic [udc7_pkg::KEY_W-1:0]      i_key_port,
    // output channel
    output      logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    output      logic [udc7_pkg::COUNT_W-1:0]    o_count_out,
    output      logic [udc7_pkg::SEG_W-1:0]      o_thousands_seg,
    output      logic [udc7_pkg::SEG_W-1:0]      o_hundreds_seg,
    output      logic [udc7_pkg::SEG_W-1:0]      o_tens_seg,
    output      logic [udc7_pkg::SEG_W-1:0]      o_ones_seg,
    output      logic [1:0]                      o_action_taken
);

    udc7_pkg::t_cfg        r_cfg;
    logic                  w_kc_valid;
    logic                  w_kc_ready;
    udc7_pkg::t_cnt_beat   w_kc_beat;
    udc7_pkg::t_conv_beat  w_out_beat;

    // config registers, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_ticks <= udc7_pkg::RST_PRESS_TICKS;
            r_cfg.count_limit <= udc7_pkg::RST_COUNT_LIMIT;
            r_cfg.up_code     <= udc7_pkg::RST_UP_CODE;
            r_cfg.down_code   <= udc7_pkg::RST_DOWN_CODE;
        end else if (i_cfg_we) begin
            unique case (udc7_pkg::t_cfg_idx'(i_cfg_index))
                udc7_pkg::CFG_PRESS_TICKS: r_cfg.press_ticks <= i_cfg_data[7:0];
                udc7_pkg::CFG_COUNT_LIMIT: r_cfg.count_limit <= i_cfg_data;
                udc7_pkg::CFG_UP_CODE:     r_cfg.up_code     <= i_cfg_data[7:0];
                udc7_pkg::CFG_DOWN_CODE:   r_cfg.down_code   <= i_cfg_data[7:0];
            endcase
        end
    end

    // debounce, release decode and count update
    udc7_key_ctrl u_key_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_key_port (i_key_port),
        .o_dn_valid (w_kc_valid),
        .i_dn_ready (w_kc_ready),
        .o_dn_beat  (w_kc_beat)
    );

    // decimal split and segment encode, last stage is the output register
    udc7_digit_pipe u_digit_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_kc_valid),
        .o_ready (w_kc_ready),
        .i_beat  (w_kc_beat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (w_out_beat)
    );

    assign o_count_out     = w_out_beat.count;
    assign o_thousands_seg = w_out_beat.th_seg;
    assign o_hundreds_seg  = w_out_beat.hu_seg;
    assign o_tens_seg      = w_out_beat.te_seg;
    assign o_ones_seg      = w_out_beat.on_seg;
    assign o_action_taken  = w_out_beat.action;

    // count stays in the four-digit range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count_out <= udc7_pkg::MAX_COUNT))
        else $error("count above display range");

    // a decrement can never land on the top value
    a_dec_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_kc_valid && (w_kc_beat.action == udc7_pkg::ACT_DEC))
            |-> (w_kc_beat.count != udc7_pkg::MAX_COUNT))
        else $error("decrement produced maximum count");

    // single-digit counts show zeros on the upper three digits
    a_leading_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_count_out < 14'd10))
            |-> (o_thousands_seg == udc7_pkg::SEG_ZERO)
             && (o_hundreds_seg == udc7_pkg::SEG_ZERO)
             && (o_tens_seg == udc7_pkg::SEG_ZERO))
        else $error("upper digit patterns wrong for single-digit count");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the debounced up/down counter with seven-segment
// digits: drives key port ticks over valid/ready, predicts every display beat
// in lockstep and checks each output beat field by field against it
// ----------------------------------------------------------------------------

module tb_top;
    import udc7_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_WAIT   = 8;        // margin past the 5-stage pipeline
    localparam int PHASE_TICKS  = 50;
    localparam int NUM_PHASES   = 6;
    localparam int PRINT_CAP    = 100;
    localparam int CLIMB_TOP    = 30;

    // active-low digit patterns, digit d lives in bits [8*d +: 8]
    localparam logic [79:0] SEG_ROM = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                       8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};

    // one expected display beat
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SEG_W-1:0]   th_seg;
        logic [SEG_W-1:0]   hu_seg;
        logic [SEG_W-1:0]   te_seg;
        logic [SEG_W-1:0]   on_seg;
        t_action            act;
    } t_disp;

    // dut ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [1:0]           i_cfg_index = '0;
    logic [COUNT_W-1:0]   i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    logic [KEY_W-1:0]     i_key_port  = KEY_IDLE;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [COUNT_W-1:0]   o_count_out;
    logic [SEG_W-1:0]     o_thousands_seg;
    logic [SEG_W-1:0]     o_hundreds_seg;
    logic [SEG_W-1:0]     o_tens_seg;
    logic [SEG_W-1:0]     o_ones_seg;
    logic [1:0]           o_action_taken;

    // register shadow, loaded with the reset defaults
    logic [KEY_W-1:0]     cfg_press_ticks = RST_PRESS_TICKS;
    logic [COUNT_W-1:0]   cfg_limit       = RST_COUNT_LIMIT;
    logic [KEY_W-1:0]     cfg_up          = RST_UP_CODE;
    logic [KEY_W-1:0]     cfg_down        = RST_DOWN_CODE;

    // predicted key/count state
    logic [KEY_W-1:0]     press_run     = '0;
    logic                 release_armed = 1'b0;
    logic [KEY_W-1:0]     held_code     = '0;
    logic [COUNT_W-1:0]   tally         = '0;

    // expected display beats, oldest first
    t_disp                display_q[$];
    t_disp                want;

    // run bookkeeping
    int                   ticks_sent   = 0;
    int                   results_seen = 0;
    int                   cfg_writes   = 0;
    int                   err_cnt      = 0;
    int                   cycle_cnt    = 0;

    // idling knobs
    bit                   tx_gaps   = 1'b0;
    bit                   rx_stalls = 1'b0;
    int                   stall_left = 0;
    int                   hold_req   = 0;
    int                   hold_ack   = 0;
    int                   hold_len   = 0;

    debounced_updown_counter_7seg_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_key_port      (i_key_port),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_count_out     (o_count_out),
        .o_thousands_seg (o_thousands_seg),
        .o_hundreds_seg  (o_hundreds_seg),
        .o_tens_seg      (o_tens_seg),
        .o_ones_seg      (o_ones_seg),
        .o_action_taken  (o_action_taken)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycle_cnt, display_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction: one key tick in, one display beat out
    // ------------------------------------------------------------------------
    function automatic t_disp next_display(input logic [KEY_W-1:0] keys);
        t_disp              d;
        logic [COUNT_W-1:0] lim;
        int                 c;
        d.act = ACT_NONE;
        // limits past full scale behave as full scale
        lim = (cfg_limit > MAX_COUNT) ? MAX_COUNT : cfg_limit;
        if (keys != KEY_IDLE) begin
            // held key: 8-bit run counter wraps, so long holds re-latch
            press_run = press_run + 8'd1;
            if (press_run == cfg_press_ticks) begin
                release_armed = 1'b1;
                held_code     = keys;
            end
        end else begin
            press_run = '0;
            if (release_armed) begin
                release_armed = 1'b0;
                // up wins when both codes are the same
                if (held_code == cfg_up) begin
                    // may pull a count above a lowered limit down to it
                    if (int'(tally) + 1 > int'(lim))
                        tally = lim;
                    else
                        tally = tally + 1'b1;
                    d.act = ACT_INC;
                end else if (held_code == cfg_down) begin
                    if (tally != '0)
                        tally = tally - 1'b1;
                    d.act = ACT_DEC;
                end
            end
        end
        c        = int'(tally);
        d.count  = tally;
        d.th_seg = SEG_ROM[(c / 1000) * 8 +: 8];
        d.hu_seg = SEG_ROM[((c / 100) % 10) * 8 +: 8];
        d.te_seg = SEG_ROM[((c / 10) % 10) * 8 +: 8];
        d.on_seg = SEG_ROM[(c % 10) * 8 +: 8];
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (err_cnt < PRINT_CAP)
            $display("mismatch at beat %0d: %s got %0h want %0h",
                     results_seen, what, got, exp_val);
        err_cnt++;
    endtask

    // outputs sampled at the rising edge, against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (display_q.size() == 0) begin
                report_mismatch("beat with nothing expected", o_count_out, 0);
            end else begin
                want = display_q.pop_front();
                if (o_count_out != want.count)
                    report_mismatch("count_out", o_count_out, want.count);
                if (o_thousands_seg != want.th_seg)
                    report_mismatch("thousands_seg", o_thousands_seg, want.th_seg);
                if (o_hundreds_seg != want.hu_seg)
                    report_mismatch("hundreds_seg", o_hundreds_seg, want.hu_seg);
                if (o_tens_seg != want.te_seg)
                    report_mismatch("tens_seg", o_tens_seg, want.te_seg);
                if (o_ones_seg != want.on_seg)
                    report_mismatch("ones_seg", o_ones_seg, want.on_seg);
                if (o_action_taken != want.act)
                    report_mismatch("action_taken", o_action_taken, want.act);
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack   = hold_req;
            stall_left = hold_len;
        end else if (stall_left == 0 && rx_stalls) begin
            case ($urandom_range(0, 99)) inside
                [0:11]:  stall_left = $urandom_range(1, 3);
                [12:13]: stall_left = $urandom_range(10, 40);
                default: stall_left = 0;
            endcase
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // sender and register access
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!tx_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one key tick; valid stays up across back-to-back beats
    task automatic send_tick(input logic [KEY_W-1:0] keys);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_key_port <= keys;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        display_q.push_back(next_display(keys));
        ticks_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop offering and wait until every expected beat is back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (display_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [COUNT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_PRESS_TICKS: cfg_press_ticks = val[KEY_W-1:0];
            CFG_COUNT_LIMIT: cfg_limit       = val;
            CFG_UP_CODE:     cfg_up          = val[KEY_W-1:0];
            CFG_DOWN_CODE:   cfg_down        = val[KEY_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    // hold a code for some ticks, then release; noise_pct swaps in random samples
    task automatic press_key(input logic [KEY_W-1:0] code, input int hold,
                             input int idle_ticks, input int noise_pct);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < hold; i++) begin
            k = code;
            if (noise_pct > 0 && $urandom_range(0, 99) < noise_pct)
                k = 8'($urandom_range(0, 255));
            send_tick(k);
        end
        repeat (idle_ticks) send_tick(KEY_IDLE);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: threshold 10, default up/down codes
    task automatic test_defaults();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_tick(KEY_IDLE);
        press_key(RST_UP_CODE, 10, 1, 0);     // accepted exactly at threshold
        press_key(RST_DOWN_CODE, 11, 1, 0);   // back to zero
        wait_idle();
    endtask

    // key port extremes, unknown code, equal codes, small and zero limits
    task automatic test_key_extremes();
        rx_stalls = 1'b1;
        write_reg(CFG_PRESS_TICKS, 14'd1);
        write_reg(CFG_UP_CODE, 14'h00);
        write_reg(CFG_DOWN_CODE, 14'hFE);
        press_key(8'h00, 1, 1, 0);            // all keys down, increment
        press_key(8'hFE, 1, 1, 0);            // decrement
        press_key(8'hFE, 1, 1, 0);            // decrement at zero
        press_key(8'h7F, 1, 1, 0);            // unknown code, no action
        wait_idle();
        write_reg(CFG_DOWN_CODE, 14'h00);     // same code both ways, up wins
        write_reg(CFG_COUNT_LIMIT, 14'd2);
        repeat (3) press_key(8'h00, 1, 1, 0); // saturate at the limit
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 14'd0);
        press_key(8'h00, 1, 1, 0);            // count pulled down to zero limit
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 14'h3FFF);
        press_key(8'h00, 1, 1, 0);
        wait_idle();
    endtask

    // climb the count into two digits, then move the limit around it
    task automatic test_count_climb();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        write_reg(CFG_COUNT_LIMIT, 14'(MAX_COUNT));
        write_reg(CFG_UP_CODE, 14'(RST_UP_CODE));
        write_reg(CFG_DOWN_CODE, 14'(RST_DOWN_CODE));
        while (int'(tally) < CLIMB_TOP)
            press_key(RST_UP_CODE, 1, 1, 0);
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 14'h3FFF); // past full scale acts as full scale
        press_key(RST_UP_CODE, 1, 1, 0);
        wait_idle();
        write_reg(CFG_COUNT_LIMIT, 14'(CLIMB_TOP - 10)); // limit lowered under the count
        press_key(RST_UP_CODE, 1, 1, 0);
        press_key(RST_DOWN_CODE, 1, 1, 0);
        wait_idle();
    endtask

    // long holds: counter wrap relatch, top threshold and threshold zero
    task automatic test_long_hold();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        write_reg(CFG_COUNT_LIMIT, 14'(MAX_COUNT));
        write_reg(CFG_PRESS_TICKS, 14'd255);
        // up latched at 255, then the down sample is relatched after the wrap
        press_key(RST_UP_CODE, 255, 0, 0);
        press_key(RST_DOWN_CODE, 256, 1, 0);
        wait_idle();
        write_reg(CFG_PRESS_TICKS, 14'd0);
        press_key(RST_UP_CODE, 256, 1, 0);    // matches when the counter wraps
        wait_idle();
    endtask

    // output held off long enough that the pipeline fills and input stalls
    task automatic test_backpressure();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        write_reg(CFG_PRESS_TICKS, 14'd2);
        hold_len = 150;
        hold_req++;
        for (int i = 0; i < 10; i++)
            press_key((i % 3 == 0) ? RST_DOWN_CODE : RST_UP_CODE, 2, 2, 0);
        // sender pauses here until every beat has come back
        wait_idle();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        for (int i = 0; i < 6; i++)
            press_key(RST_UP_CODE, 3, 1, 0);
        wait_idle();
    endtask

    // random phases: mostly well-formed presses with random content, some noise
    task automatic test_random_phases();
        int               start;
        int               pt;
        int               hold;
        logic [KEY_W-1:0] code;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(CFG_PRESS_TICKS, 14'd1);
                    write_reg(CFG_COUNT_LIMIT, 14'd0);
                    write_reg(CFG_UP_CODE, 14'($urandom_range(0, 254)));
                    write_reg(CFG_DOWN_CODE, 14'($urandom_range(0, 254)));
                end
                1: begin
                    write_reg(CFG_PRESS_TICKS, 14'($urandom_range(1, 8)));
                    write_reg(CFG_COUNT_LIMIT, 14'h3FFF);
                    write_reg(CFG_UP_CODE, 14'h00);
                    write_reg(CFG_DOWN_CODE, 14'hFF);   // can never latch
                end
                2: begin
                    // equal codes
                    code = 8'($urandom_range(0, 254));
                    write_reg(CFG_PRESS_TICKS, 14'($urandom_range(1, 8)));
                    write_reg(CFG_COUNT_LIMIT, 14'($urandom_range(0, 40)));
                    write_reg(CFG_UP_CODE, 14'(code));
                    write_reg(CFG_DOWN_CODE, 14'(code));
                end
                3: begin
                    write_reg(CFG_PRESS_TICKS, 14'($urandom_range(1, 8)));
                    write_reg(CFG_COUNT_LIMIT, 14'(MAX_COUNT));
                    write_reg(CFG_UP_CODE, 14'($urandom_range(0, 254)));
                    write_reg(CFG_DOWN_CODE, 14'($urandom_range(0, 254)));
                end
                4: begin
                    write_reg(CFG_PRESS_TICKS, 14'($urandom_range(1, 20)));
                    write_reg(CFG_COUNT_LIMIT, 14'($urandom_range(0, 16383)));
                    write_reg(CFG_UP_CODE, 14'($urandom_range(0, 255)));
                    write_reg(CFG_DOWN_CODE, 14'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(CFG_PRESS_TICKS, 14'($urandom_range(1, 8)));
                    write_reg(CFG_COUNT_LIMIT, 14'($urandom_range(0, 30)));
                    write_reg(CFG_UP_CODE, 14'($urandom_range(0, 254)));
                    write_reg(CFG_DOWN_CODE, 14'($urandom_range(0, 254)));
                end
            endcase
            // one phase runs with no idling at all
            tx_gaps   = (p != 3);
            rx_stalls = (p != 3);
            pt        = int'(cfg_press_ticks);
            start     = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                if ($urandom_range(0, 99) < 80) begin
                    case ($urandom_range(0, 9)) inside
                        [0:4]:   code = cfg_up;
                        [5:8]:   code = cfg_down;
                        default: code = 8'($urandom_range(0, 254));
                    endcase
                    if ($urandom_range(0, 9) == 0)
                        hold = $urandom_range(1, pt);   // may fall short
                    else if ($urandom_range(0, 9) < 8)
                        hold = pt + $urandom_range(0, 2);
                    else
                        hold = pt + $urandom_range(0, 8);
                    press_key(code, hold, $urandom_range(1, 3),
                              ($urandom_range(0, 4) == 0) ? 5 : 0);
                end else begin
                    // noise burst, any sample including idle
                    repeat ($urandom_range(1, 6))
                        send_tick(8'($urandom_range(0, 255)));
                end
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults();
        test_key_extremes();
        test_count_climb();
        test_long_hold();
        test_backpressure();
        test_random_phases();

        wait_idle();
        if (display_q.size() != 0)
            report_mismatch("beats never delivered", 0, display_q.size());

        $display("covered %0d key ticks and %0d register writes, %0d display beats checked",
                 ticks_sent, cfg_writes, results_seen);
        $display("incl. count climb, wrap relatch, zero/top thresholds, hold-off");
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
